>>> src/md5_pkg.sv
// MD5 package: item types, opcodes, round constants, shift amounts and word-index functions.
// No dependencies; used by every module in src.
`timescale 1ns / 1ps
package md5_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_APPEND_FINISH = 2'd1,
    OP_FINISH = 2'd2,
    OP_ABANDON = 2'd3
  } md5_op_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic last_word;
  } md5_out_t;

  // Byte command passed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_DIGEST = 2'd1,
    CMD_CLEAR = 2'd2
  } md5_cmd_t;

  typedef struct packed {
    md5_cmd_t cmd;
    logic [7:0] data;
  } md5_job_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_PAD,
    FS_LEN,
    FS_DONE
  } md5_fstate_t;

  typedef enum logic [1:0] {
    BS_FILL,
    BS_ROUND,
    BS_EMIT
  } md5_bstate_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word index used in step i.
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    lo = i[3:0];
    case (i[5:4])
      2'd0: msg_index = lo;
      2'd1: msg_index = 4'((lo << 2) + lo + 4'd1);
      2'd2: msg_index = 4'((lo << 1) + lo + 4'd5);
      default: msg_index = 4'((lo << 3) - lo);
    endcase
  endfunction

endpackage

>>> src/md5_front.sv
// MD5 front part: accepts items, tracks the message length and expands a finish
// into padding and length bytes. Depends on md5_pkg.
`timescale 1ns / 1ps
module md5_front import md5_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  md5_in_t in_item,
  output logic job_valid,
  input  logic job_ready,
  output md5_job_t job
);

  md5_fstate_t state, state_next;
  logic [63:0] bit_count, bit_count_next;
  logic [63:0] len_bits, len_bits_next;
  logic [5:0] pos;
  logic [2:0] len_idx, len_idx_next;

  assign pos = bit_count[8:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
      bit_count <= '0;
      len_idx <= '0;
    end else begin
      state <= state_next;
      bit_count <= bit_count_next;
      len_idx <= len_idx_next;
    end
    len_bits <= len_bits_next;
  end

  // Byte sequencer: pass-through when idle, then padding, length and digest request.
  always_comb begin
    state_next = state;
    bit_count_next = bit_count;
    len_bits_next = len_bits;
    len_idx_next = len_idx;
    in_ready = 1'b0;
    job_valid = 1'b0;
    job = '{cmd: CMD_BYTE, data: in_item.data_byte};
    unique case (state)
      FS_IDLE: begin
        in_ready = job_ready;
        job_valid = in_valid;
        unique case (md5_op_t'(in_item.opcode))
          OP_APPEND, OP_APPEND_FINISH: job.cmd = CMD_BYTE;
          OP_FINISH: begin
            job.cmd = CMD_BYTE;
            job.data = PAD_BYTE;
          end
          default: job.cmd = CMD_CLEAR;
        endcase
        if (in_valid && job_ready) begin
          unique case (md5_op_t'(in_item.opcode))
            OP_APPEND: bit_count_next = bit_count + 64'd8;
            OP_APPEND_FINISH: begin
              // Send the byte now; the pad byte follows next.
              len_bits_next = bit_count + 64'd8;
              bit_count_next = bit_count + 64'd8;
              state_next = FS_PAD;
            end
            OP_FINISH: begin
              len_bits_next = bit_count;
              bit_count_next = bit_count + 64'd16;
              state_next = FS_PAD;
            end
            default: bit_count_next = '0;
          endcase
        end
        if (in_valid && md5_op_t'(in_item.opcode) == OP_FINISH) begin
          // A finish without a byte has already sent its pad byte.
          if (job_ready) state_next = (bit_count[8:3] + 6'd1 == LEN_POS) ? FS_LEN : FS_PAD;
          if (job_ready) bit_count_next = bit_count + 64'd8;
        end
      end
      FS_PAD: begin
        job_valid = 1'b1;
        // The first pad byte after a data byte is 0x80.
        job.data = (bit_count == len_bits) ? PAD_BYTE : 8'h00;
        if (job_ready) begin
          bit_count_next = bit_count + 64'd8;
          if (pos + 6'd1 == LEN_POS) state_next = FS_LEN;
        end
      end
      FS_LEN: begin
        job_valid = 1'b1;
        job.data = len_bits[{len_idx, 3'b000} +: 8];
        if (job_ready) begin
          len_idx_next = len_idx + 3'd1;
          if (len_idx == 3'd7) state_next = FS_DONE;
        end
      end
      default: begin
        job_valid = 1'b1;
        job.cmd = CMD_DIGEST;
        if (job_ready) begin
          bit_count_next = '0;
          state_next = FS_IDLE;
        end
      end
    endcase
  end

endmodule

>>> src/md5_queue.sv
// Two-entry job queue between the MD5 front and back parts.
// Depends on md5_pkg.
`timescale 1ns / 1ps
module md5_queue import md5_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  md5_job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output md5_job_t rd_job
);

  md5_job_t slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_job = slots[rd_ptr];

  // Pointer and occupancy update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (wr_valid && wr_ready) wr_ptr <= ~wr_ptr;
      if (rd_valid && rd_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'((wr_valid && wr_ready) ? 1 : 0) - 2'((rd_valid && rd_ready) ? 1 : 0);
    end
    if (wr_valid && wr_ready) slots[wr_ptr] <= wr_job;
  end

endmodule

>>> src/md5_back.sv
// MD5 back part: block buffer, 64-step compression and digest output register.
// Depends on md5_pkg.
`timescale 1ns / 1ps
module md5_back import md5_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  md5_job_t job,
  output logic out_valid,
  input  logic out_ready,
  output md5_out_t out_item
);

  md5_bstate_t state, state_next;
  logic [31:0] words [16];
  logic [31:0] h [4];
  logic [31:0] a, b, c, d;
  logic [5:0] pos;
  logic [5:0] step;
  logic [1:0] emit_idx;
  logic [31:0] f, sum, rot, m;
  logic [4:0] s;
  logic fill_done;

  assign fill_done = state == BS_FILL && job_valid && job.cmd == CMD_BYTE && pos == 6'd63;

  // Round function of the current step.
  always_comb begin
    case (step[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    m = words[msg_index(step)];
    s = ROT_S[{step[5:4], step[1:0]}];
    sum = a + f + ROUND_K[step] + m;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_comb begin
    state_next = state;
    job_ready = 1'b0;
    unique case (state)
      BS_FILL: begin
        job_ready = 1'b1;
        if (job_valid) begin
          if (fill_done) state_next = BS_ROUND;
          else if (job.cmd == CMD_DIGEST) state_next = BS_EMIT;
        end
      end
      BS_ROUND: if (step == 6'd63) state_next = BS_FILL;
      default: if (out_ready && emit_idx == 2'd3) state_next = BS_FILL;
    endcase
  end

  assign out_valid = state == BS_EMIT;
  assign out_item = '{digest_word: h[emit_idx], last_word: emit_idx == 2'd3};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_FILL;
      pos <= '0;
      step <= '0;
      emit_idx <= '0;
      h <= '{IV_A, IV_B, IV_C, IV_D};
    end else begin
      state <= state_next;
      unique case (state)
        BS_FILL: if (job_valid) begin
          if (job.cmd == CMD_BYTE) pos <= pos + 6'd1;
          if (job.cmd == CMD_CLEAR) begin
            pos <= '0;
            h <= '{IV_A, IV_B, IV_C, IV_D};
          end
          if (fill_done) step <= '0;
        end
        BS_ROUND: begin
          step <= step + 6'd1;
          if (step == 6'd63) begin
            h[0] <= h[0] + d;
            h[1] <= h[1] + b + rot;
            h[2] <= h[2] + b;
            h[3] <= h[3] + c;
          end
        end
        default: if (out_ready) begin
          emit_idx <= emit_idx + 2'd1;
          if (emit_idx == 2'd3) begin
            pos <= '0;
            h <= '{IV_A, IV_B, IV_C, IV_D};
          end
        end
      endcase
    end
    // Working variables and block words carry no reset.
    if (state == BS_FILL && job_valid && job.cmd == CMD_BYTE)
      words[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= job.data;
    if (fill_done) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
    end else if (state == BS_ROUND) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b + rot;
    end
  end

endmodule

>>> src/md5_message_digest_unit.sv
// MD5 digest unit top level: front sequencer, job queue and compression back end.
// Depends on md5_pkg, md5_front, md5_queue and md5_back.
//
//   channel  direction  payload    handshake
//   in       input      md5_in_t   in_valid / in_ready
//   out      output     md5_out_t  out_valid / out_ready
//
// The 64th byte of a block starts compression in the single round unit, during
// which up to two more bytes queue.
// A finish expands to 9..72 padding/length bytes, then four digest words.
// Reset is synchronous and restores the initial chaining value.
// Either side may stall; the queue decouples input acceptance from compression.
`timescale 1ns / 1ps
module md5_message_digest_unit import md5_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  md5_in_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output md5_out_t out_item
);

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  md5_job_t fq_job, qb_job;

  md5_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  md5_queue u_queue (
    .clk, .rst, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
  );

  md5_back u_back (
    .clk, .rst, .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .out_valid, .out_ready, .out_item
  );

endmodule
